// ===== hdl/stidq_pkg.sv =====
// shared types and codes for the sorted table engine
`default_nettype none

package stidq_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] position;
        logic [7:0] entries_held;
    } out_word_t;

    typedef struct packed {
        logic capture;
        logic insert;
        logic delete;
        logic found;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_APPLY,
        FSM_SEARCH
    } fsm_state_t;

endpackage

`default_nettype wire

// ===== hdl/stidq_cell.sv =====
// one table cell: holds an entry, compares it with the key, shifts with its neighbors
`default_nettype none

module stidq_cell #(
    parameter int DEPTH = 128,
    parameter int INDEX = 0
) (
    input  wire                                    clk,
    input  stidq_pkg::cell_ctrl_t                  ctrl,
    input  wire  [$clog2(DEPTH+1)-1:0]             count,
    input  wire  signed [31:0]                     cmp_key,
    input  wire  signed [31:0]                     key,
    input  wire  signed [31:0]                     left_entry,
    input  wire                                    left_lt,
    input  wire                                    left_eq,
    input  wire  signed [31:0]                     right_entry,
    output logic signed [31:0]                     entry,
    output logic                                   lt,
    output logic                                   eq,
    output logic                                   mark_ins,
    output logic                                   mark_del
);
    import stidq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;
    logic               lt_reg;
    logic               eq_reg;
    logic               valid;
    logic               tail;

    assign valid = CNT_W'(INDEX) < count;
    assign tail  = CNT_W'(INDEX) == count;

    assign lt       = lt_reg & valid;
    assign eq       = eq_reg & valid;
    assign mark_ins = !left_lt & (lt | tail);
    assign mark_del = eq & !left_eq;
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert)
        begin
            if (left_lt)
            begin
                entry_next = left_entry;
            end
            else if (lt || !valid)
            begin
                entry_next = key;
            end
        end
        else if (ctrl.delete && ctrl.found && (lt || eq))
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (ctrl.capture)
        begin
            lt_reg <= cmp_key < entry_reg;
            eq_reg <= cmp_key == entry_reg;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sorted_table_insert_delete_query.sv =====
// top level of the sorted table engine: cell chain, request sequencer and output register
`default_nettype none

// Sorted table engine. Holds up to TABLE_DEPTH signed 32-bit entries in ascending
// order, one per cell of a chain, and serves one request per input word: insert
// (before the first larger entry), delete (first equal entry) or query (binary
// search). Every request returns one output word with status, position and the
// entry count afterwards. All cells compare the key with their entry at the edge
// that accepts the word; insert and delete then shift the chain in the APPLY
// state once the output register is free. A query walks the binary search over
// the registered compare flags one probe per cycle. A new word is taken as soon
// as the previous result sits in the output register; a full output register
// that is still stalled holds the engine at its last step. The table needs no
// clearing after reset.
module sorted_table_insert_delete_query #(
    parameter int TABLE_DEPTH = 128
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_stall,
    input  stidq_pkg::in_word_t   in_word,
    output logic                  out_valid,
    input  wire                   out_stall,
    output stidq_pkg::out_word_t  out_word
);
    import stidq_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    fsm_state_t          state_reg;
    fsm_state_t          state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    lo_reg;
    logic [CNT_W-1:0]    lo_next;
    logic [CNT_W-1:0]    hi_reg;
    logic [CNT_W-1:0]    hi_next;
    logic [1:0]          op_reg;
    logic signed [31:0]  key_reg;
    logic                out_valid_reg;
    out_word_t           out_word_reg;

    logic                accept;
    logic                out_free;
    logic                load_out;
    out_word_t           res;
    cell_ctrl_t          ctrl;

    logic signed [31:0]  entry_w [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] lt_vec;
    logic [TABLE_DEPTH-1:0] eq_vec;
    logic [TABLE_DEPTH-1:0] ins_vec;
    logic [TABLE_DEPTH-1:0] del_vec;

    logic [IDX_W-1:0]    ins_pos;
    logic [IDX_W-1:0]    del_pos;
    logic                found;
    logic                full;
    logic [CNT_W:0]      mid_sum;
    logic [IDX_W-1:0]    mid;
    logic                search_end;

    assign accept    = in_valid && (state_reg == FSM_IDLE);
    assign in_stall  = state_reg != FSM_IDLE;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign found      = |del_vec;
    assign full       = count_reg == CNT_W'(TABLE_DEPTH);
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg} - (CNT_W + 1)'(1);
    assign mid        = mid_sum[IDX_W:1];
    assign search_end = lo_reg >= hi_reg;

    // cell chain
    genvar j;
    generate
        for (j = 0; j < TABLE_DEPTH; j++)
        begin : g_cell
            logic signed [31:0] left_entry;
            logic               left_lt;
            logic               left_eq;
            logic signed [31:0] right_entry;

            if (j == 0)
            begin : g_first
                assign left_entry = entry_w[j];
                assign left_lt    = 1'b0;
                assign left_eq    = 1'b0;
            end
            else
            begin : g_inner
                assign left_entry = entry_w[j-1];
                assign left_lt    = lt_vec[j-1];
                assign left_eq    = eq_vec[j-1];
            end

            if (j == TABLE_DEPTH - 1)
            begin : g_last
                assign right_entry = entry_w[j];
            end
            else
            begin : g_body
                assign right_entry = entry_w[j+1];
            end

            stidq_cell #(
                .DEPTH (TABLE_DEPTH),
                .INDEX (j)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .count       (count_reg),
                .cmp_key     (in_word.value),
                .key         (key_reg),
                .left_entry  (left_entry),
                .left_lt     (left_lt),
                .left_eq     (left_eq),
                .right_entry (right_entry),
                .entry       (entry_w[j]),
                .lt          (lt_vec[j]),
                .eq          (eq_vec[j]),
                .mark_ins    (ins_vec[j]),
                .mark_del    (del_vec[j])
            );
        end
    endgenerate

    // one-hot to index
    always_comb
    begin
        ins_pos = '0;
        del_pos = '0;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            if (ins_vec[k])
            begin
                ins_pos = ins_pos | IDX_W'(k);
            end
            if (del_vec[k])
            begin
                del_pos = del_pos | IDX_W'(k);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_word.req_type == REQ_QUERY) ? FSM_SEARCH : FSM_APPLY;
                end
            end
            FSM_APPLY:
            begin
                if (out_free)
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_SEARCH:
            begin
                if (out_free && (search_end || eq_vec[mid]))
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        count_next   = count_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        load_out     = 1'b0;
        res          = '0;
        ctrl         = '0;
        ctrl.capture = accept;
        ctrl.found   = found;
        res.status   = ST_MISSING;
        res.entries_held = 8'(count_reg);
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    lo_next = '0;
                    hi_next = count_reg;
                end
            end
            FSM_APPLY:
            begin
                load_out = out_free;
                unique case (op_reg)
                    REQ_INSERT:
                    begin
                        if (full)
                        begin
                            res.status = ST_FULL;
                        end
                        else
                        begin
                            res.status       = ST_OK;
                            res.position     = 7'(ins_pos);
                            res.entries_held = 8'(count_reg + CNT_W'(1));
                            ctrl.insert      = out_free;
                            if (out_free)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                    end
                    REQ_DELETE:
                    begin
                        if (found)
                        begin
                            res.status       = ST_OK;
                            res.position     = 7'(del_pos);
                            res.entries_held = 8'(count_reg - CNT_W'(1));
                            ctrl.delete      = out_free;
                            if (out_free)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                        res.status = ST_MISSING;
                    end
                endcase
            end
            FSM_SEARCH:
            begin
                if (search_end)
                begin
                    load_out = out_free;
                end
                else if (eq_vec[mid])
                begin
                    load_out     = out_free;
                    res.status   = ST_OK;
                    res.position = 7'(mid);
                end
                else if (lt_vec[mid])
                begin
                    hi_next = CNT_W'(mid);
                end
                else
                begin
                    lo_next = CNT_W'(mid) + CNT_W'(1);
                end
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= in_word.req_type;
            key_reg <= in_word.value;
        end
        if (load_out)
        begin
            out_word_reg <= res;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_word.status == ST_FULL) |-> count_reg == CNT_W'(TABLE_DEPTH))
        else $error("full status while table has room");

    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg)
                  || count_reg == $past(count_reg) + CNT_W'(1)
                  || count_reg + CNT_W'(1) == $past(count_reg)))
        else $error("entry count moved by more than one");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == FSM_APPLY && out_valid))
        else $error("entry count changed without a result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_SEARCH) |-> (hi_reg <= count_reg))
        else $error("search bound beyond table");

endmodule

`default_nettype wire

// ===== tb/sv/tb_sorted_table_insert_delete_query.sv =====
// self-checking testbench for the sorted table engine with a table scoreboard
module tb_sorted_table_insert_delete_query;
    import stidq_pkg::*;

    localparam int         DEPTH       = 128;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         RANDOM_WORDS = 1650;
    localparam int         CYCLE_LEN   = 550;

    class table_scoreboard;
        logic signed [31:0] entries[$];
        out_word_t          expected_q[$];
        int errors;
        int n_insert, n_delete, n_query, n_unused, n_full, n_missing, n_checked;
        int peak_fill;

        function void note_request(in_word_t w);
            out_word_t          r;
            logic signed [31:0] key;
            int                 i, lo, hi, mid;
            key = w.value;
            r = '0;
            r.status = ST_OK;
            case (w.req_type)
                REQ_INSERT:
                begin
                    n_insert++;
                    if (entries.size() >= DEPTH) begin
                        r.status = ST_FULL;
                        n_full++;
                    end else begin
                        i = 0;
                        while (i < entries.size() && !(key < entries[i]))
                            i++;
                        entries.insert(i, key);
                        r.position = 7'(i);
                    end
                end
                REQ_DELETE:
                begin
                    n_delete++;
                    i = 0;
                    while (i < entries.size() && entries[i] != key)
                        i++;
                    if (i >= entries.size()) begin
                        r.status = ST_MISSING;
                    end else begin
                        entries.delete(i);
                        r.position = 7'(i);
                    end
                end
                REQ_QUERY:
                begin
                    n_query++;
                    lo = 0;
                    hi = entries.size() - 1;
                    r.status = ST_MISSING;
                    while (lo <= hi) begin
                        mid = (lo + hi) / 2;
                        if (key == entries[mid]) begin
                            r.status = ST_OK;
                            r.position = 7'(mid);
                            break;
                        end
                        if (key < entries[mid])
                            hi = mid - 1;
                        else
                            lo = mid + 1;
                    end
                end
                default:
                begin
                    n_unused++;
                    r.status = ST_MISSING;
                end
            endcase
            if (r.status == ST_MISSING)
                n_missing++;
            r.entries_held = 8'(entries.size());
            if (entries.size() > peak_fill)
                peak_fill = entries.size();
            expected_q.push_back(r);
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: status %0d position %0d count %0d",
                             got.status, got.position, got.entries_held);
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (got.status !== want.status || got.position !== want.position
                || got.entries_held !== want.entries_held) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch at result %0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
                             n_checked, want.status, want.position, want.entries_held,
                             got.status, got.position, got.entries_held);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_word;

    table_scoreboard sb;

    sorted_table_insert_delete_query #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word (out_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.note_request(in_word);
            if (out_valid && !out_stall)
                sb.check_result(out_word);
        end
    end

    // receiver stall pattern, switching at random among four stall modes
    int stall_mode;
    int stall_run;
    int mode_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_mode <= 0;
            stall_run <= 0;
            mode_left <= 0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(64, 400);
            end else begin
                mode_left <= mode_left - 1;
            end
            if (stall_run == 0) begin
                case (stall_mode)
                    0:
                    begin
                        out_stall <= 1'b0;
                        stall_run <= $urandom_range(1, 40);
                    end
                    1:
                    begin
                        out_stall <= ($urandom_range(0, 4) == 0);
                        stall_run <= 0;
                    end
                    2:
                    begin
                        out_stall <= ($urandom_range(0, 3) != 0);
                        stall_run <= $urandom_range(0, 2);
                    end
                    default:
                    begin
                        out_stall <= $urandom_range(0, 1);
                        stall_run <= $urandom_range(1, 30);
                    end
                endcase
            end else begin
                stall_run <= stall_run - 1;
            end
        end
    end

    task automatic send_word(input logic [1:0] kind, input logic signed [31:0] key);
        in_word_t w;
        w.req_type = kind;
        w.value = key;
        in_word <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_value(input bit from_table);
        int sel;
        sel = $urandom_range(0, 99);
        if (from_table && sb.entries.size() != 0 && sel < 65)
            return sb.entries[$urandom_range(0, sb.entries.size() - 1)];
        if (sel < 80)
            return $signed($urandom_range(0, 16)) - 8;
        if (sel < 86)
            return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        return $urandom;
    endfunction

    int burst_left;
    int gap_max;
    int gap_len;
    int sent;
    int pos_in_cycle;
    int sel;
    int ins_pct;
    int del_pct;
    int drain_wait;
    logic [1:0] kind;

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, extremes, duplicates, absent keys, unused code
        send_word(REQ_QUERY, 0);
        send_word(REQ_DELETE, 5);
        send_word(REQ_UNUSED, 0);
        send_word(REQ_INSERT, 0);
        send_word(REQ_INSERT, 32'sh7fffffff);
        send_word(REQ_INSERT, 32'sh80000000);
        send_word(REQ_INSERT, 0);
        send_word(REQ_INSERT, 0);
        send_word(REQ_INSERT, -1);
        send_word(REQ_INSERT, 1);
        send_word(REQ_QUERY, 0);
        send_word(REQ_QUERY, 32'sh7fffffff);
        send_word(REQ_QUERY, 32'sh80000000);
        send_word(REQ_QUERY, 2);
        send_word(REQ_DELETE, 0);
        send_word(REQ_DELETE, 7);
        send_word(REQ_DELETE, 32'sh7fffffff);
        send_word(REQ_DELETE, 32'sh80000000);
        send_word(REQ_UNUSED, -1);
        send_word(REQ_INSERT, 32'sh55555555);
        send_word(REQ_INSERT, 32'shaaaaaaaa);
        send_word(REQ_QUERY, 32'sh55555555);
        send_word(REQ_DELETE, 32'shaaaaaaaa);
        send_word(REQ_QUERY, -1);

        // fill to full, churn, then drain, repeated
        burst_left = 0;
        gap_max = 4;
        for (sent = 0; sent < RANDOM_WORDS; sent++) begin
            pos_in_cycle = sent % CYCLE_LEN;
            if (pos_in_cycle < 190) begin
                ins_pct = 85;
                del_pct = 5;
            end else if (pos_in_cycle < 380) begin
                ins_pct = 34;
                del_pct = 33;
            end else begin
                ins_pct = 10;
                del_pct = 75;
            end
            if (pos_in_cycle % 120 == 0)
                gap_max = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
            sel = $urandom_range(0, 99);
            if (sel < 3)
                kind = REQ_UNUSED;
            else if (sel < 3 + ins_pct)
                kind = REQ_INSERT;
            else if (sel < 3 + ins_pct + del_pct)
                kind = REQ_DELETE;
            else
                kind = REQ_QUERY;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap_len = $urandom_range(0, gap_max);
                if (gap_len != 0) begin
                    in_valid <= 1'b0;
                    repeat (gap_len) @(posedge clk);
                end
            end
            send_word(kind, pick_value(kind != REQ_INSERT));
            burst_left--;
        end
        in_valid <= 1'b0;

        drain_wait = 0;
        while (sb.expected_q.size() != 0 && drain_wait < 20000) begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (30) @(posedge clk);
        if (sb.expected_q.size() != 0) begin
            $display("%0d result words never arrived", sb.expected_q.size());
            sb.errors += sb.expected_q.size();
        end

        $display("covered %0d inserts (%0d refused on a full table), %0d deletes, %0d queries",
                 sb.n_insert, sb.n_full, sb.n_delete, sb.n_query);
        $display("plus %0d unused codes; %0d not-found answers, table peaked at %0d of %0d",
                 sb.n_unused, sb.n_missing, sb.peak_fill, DEPTH);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
